FILE: rtl/core/voxel_ray_traversal_defines.svh
// Assertion macros for the voxel ray walker.
// Used by the top level only; no other dependency.
`ifndef VOXEL_RAY_TRAVERSAL_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_DEFINES_SVH

// same-cycle implication
`define VRT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("vrt assertion failed");

// next-cycle implication
`define VRT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("vrt assertion failed");

`endif

FILE: rtl/core/vrt_pkg.sv
// Shared types and constants for the voxel ray walker.
// No dependencies.
package vrt_pkg;

    localparam int ORG_W  = 32;
    localparam int DIR_W  = 18;
    localparam int LEN_W  = 32;
    localparam int VOX_W  = 16;
    localparam int KIND_W = 2;
    localparam int BND_W  = 32;

    // input word layout, lowest bit first
    localparam int IN_OX  = 0;
    localparam int IN_OY  = IN_OX + ORG_W;
    localparam int IN_OZ  = IN_OY + ORG_W;
    localparam int IN_DX  = IN_OZ + ORG_W;
    localparam int IN_DY  = IN_DX + DIR_W;
    localparam int IN_DZ  = IN_DY + DIR_W;
    localparam int IN_LEN = IN_DZ + DIR_W;
    localparam int IN_SOL = IN_LEN + LEN_W;
    localparam int IN_TDATA_W = ((IN_SOL + 1 + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 3 * VOX_W;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_ANSWER = 1'b1;

    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_HIT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MISS  = 2'd2;

    typedef enum logic [1:0] {
        VSEL_CUR  = 2'd0,
        VSEL_PREV = 2'd1,
        VSEL_NONE = 2'd2
    } t_vsel;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_SETUP = 12'b0000_0000_0010,
        S_DIV1  = 12'b0000_0000_0100,
        S_DIV2  = 12'b0000_0000_1000,
        S_CHK   = 12'b0000_0001_0000,
        S_ABS   = 12'b0000_0010_0000,
        S_SQ    = 12'b0000_0100_0000,
        S_ACC   = 12'b0000_1000_0000,
        S_LSQ   = 12'b0001_0000_0000,
        S_CMP   = 12'b0010_0000_0000,
        S_STEP  = 12'b0100_0000_0000,
        S_EMIT  = 12'b1000_0000_0000
    } t_state;

endpackage

FILE: rtl/core/voxel_ray_traversal.sv
// Voxel ray walker: top level with sequencer, shared multiplier and setup divider.
// Depends on vrt_pkg, vrt_div and voxel_ray_traversal_defines.svh.
`include "voxel_ray_traversal_defines.svh"

// A start word (tuser 0) sets up a ray: per moving axis two divisions run on the shared
// bit-serial divider, then one distance check and step follows and a query word comes out
// (a ray with no moving axis gives a miss at once, and a miss found on an early axis comes
// out sooner). Each answer word (tuser 1) during a walk either ends the walk with a hit at
// once or runs the same check and step (answers outside a walk are dropped):
// the distance check squares the three offsets and the length one after another on
// a single 32x32 multiplier. A miss word carries zero coordinates. The input is taken
// only while the sequencer is idle; a result waits in the output register without
// blocking the next word.
module voxel_ray_traversal #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic                               i_cfg_wr_data,   // ahead_mode
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, ray_length, voxel_solid, pad
    input  logic [vrt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tuser,    // action
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // voxel_x, voxel_y, voxel_z
    output logic [vrt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic [vrt_pkg::KIND_W-1:0]         m_axis_tuser     // kind
);
    import vrt_pkg::*;

    localparam int QW  = (2 * FRAC_BITS + 1 > BND_W + 1) ? 2 * FRAC_BITS + 1 : BND_W + 1;
    localparam int DDW = ((COORD_BITS + FRAC_BITS > ORG_W) ? COORD_BITS + FRAC_BITS
                                                             : ORG_W) + 1;
    localparam int SW  = 2 * LEN_W + 2;

    t_state                         r_state;
    logic [1:0]                     r_ax;
    logic signed [ORG_W-1:0]        r_org  [3];
    logic signed [DIR_W-1:0]        r_dir  [3];
    logic [LEN_W-1:0]               r_len;
    logic signed [COORD_BITS-1:0]   r_cur  [3];
    logic signed [COORD_BITS-1:0]   r_prev [3];
    logic [BND_W-1:0]               r_nb   [3];
    logic [BND_W-1:0]               r_inc  [3];
    logic signed [1:0]              r_sign [3];
    logic                           r_first;
    logic                           r_walk;
    logic                           r_ahead;
    logic [LEN_W-1:0]               r_a;
    logic [2*LEN_W-1:0]             r_prod;
    logic [SW-1:0]                  r_sum;
    logic [KIND_W-1:0]              r_pend_kind;
    t_vsel                          r_pend_sel;
    logic                           r_ov;
    logic [KIND_W-1:0]              r_okind;
    logic [OUT_TDATA_W-1:0]         r_odata;

    logic                           w_acc;
    logic signed [DIR_W-1:0]        w_dir;
    logic [DIR_W-1:0]               w_ad;
    logic [FRAC_BITS-1:0]           w_fr;
    logic [FRAC_BITS-1:0]           w_dist;
    logic signed [63:0]             w_org64;
    logic signed [63:0]             w_fl;
    logic                           w_div_start;
    logic [QW-1:0]                  w_dvd;
    logic                           w_div_done;
    logic [BND_W-1:0]               w_quot;
    logic signed [DDW-1:0]          w_d;
    logic [DDW-1:0]                 w_absd;
    logic [1:0]                     w_sel;
    logic [BND_W:0]                 w_nbsum;
    logic [OUT_TDATA_W-1:0]         w_emit;

    assign w_acc = s_axis_tvalid && s_axis_tready;

    // setup arithmetic for the axis in hand
    assign w_dir   = r_dir[r_ax];
    assign w_ad    = (w_dir < 0) ? DIR_W'(-w_dir) : DIR_W'(w_dir);
    assign w_fr    = r_org[r_ax][FRAC_BITS-1:0];
    assign w_dist  = (w_dir > 0) ? FRAC_BITS'(-w_fr) : w_fr;
    assign w_org64 = 64'(r_org[r_ax]);
    assign w_fl    = w_org64 >>> FRAC_BITS;

    assign w_div_start = (r_state == S_SETUP && w_dir != '0) || (r_state == S_DIV1 && w_div_done);
    assign w_dvd = (r_state == S_SETUP) ? (QW'(1) << (2 * FRAC_BITS))
                                        : (QW'(w_dist) << FRAC_BITS);

    vrt_div #(.QW(QW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_ad),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // offset of the origin from the current voxel corner
    assign w_d    = DDW'(r_org[r_ax]) - (DDW'(r_cur[r_ax]) <<< FRAC_BITS);
    assign w_absd = (w_d < 0) ? DDW'(-w_d) : DDW'(w_d);

    // step axis: smallest boundary among moving axes, x before y before z
    always_comb begin
        if (r_sign[0] != '0 && (r_sign[1] == '0 || r_nb[0] <= r_nb[1]) &&
            (r_sign[2] == '0 || r_nb[0] <= r_nb[2])) begin
            w_sel = 2'd0;
        end else if (r_sign[1] != '0 && (r_sign[2] == '0 || r_nb[1] <= r_nb[2])) begin
            w_sel = 2'd1;
        end else begin
            w_sel = 2'd2;
        end
    end
    assign w_nbsum = {1'b0, r_nb[w_sel]} + {1'b0, r_inc[w_sel]};

    always_comb begin
        case (r_pend_sel)
            VSEL_CUR:  w_emit = {VOX_W'(r_cur[2]), VOX_W'(r_cur[1]), VOX_W'(r_cur[0])};
            VSEL_PREV: w_emit = {VOX_W'(r_prev[2]), VOX_W'(r_prev[1]), VOX_W'(r_prev[0])};
            default:   w_emit = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= '0;
            r_first <= 1'b1;
            r_walk  <= 1'b0;
            r_ahead <= 1'b0;
            r_ov    <= 1'b0;
            r_len   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_org[i]  <= '0;
                r_dir[i]  <= '0;
                r_cur[i]  <= '0;
                r_prev[i] <= '0;
                r_nb[i]   <= '0;
                r_inc[i]  <= '0;
                r_sign[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_ahead <= i_cfg_wr_data;
            end
            if (r_ov && m_axis_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc && s_axis_tuser == ACT_START) begin
                        r_org[0] <= s_axis_tdata[IN_OX +: ORG_W];
                        r_org[1] <= s_axis_tdata[IN_OY +: ORG_W];
                        r_org[2] <= s_axis_tdata[IN_OZ +: ORG_W];
                        r_dir[0] <= s_axis_tdata[IN_DX +: DIR_W];
                        r_dir[1] <= s_axis_tdata[IN_DY +: DIR_W];
                        r_dir[2] <= s_axis_tdata[IN_DZ +: DIR_W];
                        r_len    <= s_axis_tdata[IN_LEN +: LEN_W];
                        r_first  <= 1'b1;
                        r_walk   <= 1'b0;
                        r_ax     <= '0;
                        r_state  <= S_SETUP;
                    end else if (w_acc && r_walk) begin
                        if (s_axis_tdata[IN_SOL] && (!r_ahead || !r_first)) begin
                            r_walk      <= 1'b0;
                            r_pend_kind <= KIND_HIT;
                            r_pend_sel  <= r_ahead ? VSEL_PREV : VSEL_CUR;
                            r_state     <= S_EMIT;
                        end else begin
                            for (int i = 0; i < 3; i++) begin
                                r_prev[i] <= r_cur[i];
                            end
                            r_first <= 1'b0;
                            r_ax    <= '0;
                            r_sum   <= '0;
                            r_state <= S_ABS;
                        end
                    end
                end
                S_SETUP: begin
                    r_cur[r_ax]  <= w_fl[COORD_BITS-1:0];
                    r_prev[r_ax] <= w_fl[COORD_BITS-1:0];
                    r_sign[r_ax] <= (w_dir > 0) ? 2'sd1 : ((w_dir < 0) ? -2'sd1 : 2'sd0);
                    if (w_dir == '0) begin
                        r_inc[r_ax] <= '1;
                        r_nb[r_ax]  <= '1;
                        r_ax        <= r_ax + 1'b1;
                        r_state     <= (r_ax == 2'd2) ? S_CHK : S_SETUP;
                    end else begin
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_div_done) begin
                        r_inc[r_ax] <= w_quot;
                        r_state     <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_div_done) begin
                        r_nb[r_ax] <= w_quot;
                        r_ax       <= r_ax + 1'b1;
                        r_state    <= (r_ax == 2'd2) ? S_CHK : S_SETUP;
                    end
                end
                S_CHK: begin
                    r_ax  <= '0;
                    r_sum <= '0;
                    if (r_sign[0] == '0 && r_sign[1] == '0 && r_sign[2] == '0) begin
                        r_pend_kind <= KIND_MISS;
                        r_pend_sel  <= VSEL_NONE;
                        r_state     <= S_EMIT;
                    end else begin
                        r_walk  <= 1'b1;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_a <= w_absd[LEN_W-1:0];
                    if (w_absd > DDW'(r_len)) begin
                        // one axis alone is past the length
                        r_walk      <= 1'b0;
                        r_pend_kind <= KIND_MISS;
                        r_pend_sel  <= VSEL_NONE;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod  <= r_a * r_a;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    // load the length for the last square; the next axis overwrites it
                    r_a     <= r_len;
                    r_sum   <= r_sum + SW'(r_prod);
                    r_ax    <= r_ax + 1'b1;
                    r_state <= (r_ax == 2'd2) ? S_LSQ : S_ABS;
                end
                S_LSQ: begin
                    r_prod  <= r_a * r_a;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_sum > SW'(r_prod)) begin
                        r_walk      <= 1'b0;
                        r_pend_kind <= KIND_MISS;
                        r_pend_sel  <= VSEL_NONE;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_cur[w_sel] <= r_cur[w_sel] + COORD_BITS'(r_sign[w_sel]);
                    r_nb[w_sel]  <= w_nbsum[BND_W] ? '1 : w_nbsum[BND_W-1:0];
                    r_pend_kind  <= KIND_QUERY;
                    r_pend_sel   <= VSEL_CUR;
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_okind <= r_pend_kind;
                        r_odata <= w_emit;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = r_odata;

    `VRT_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == KIND_MISS, m_axis_tdata == '0)
    `VRT_ASSERT_IMPL(a_div_done, i_clk, i_rst_n, w_div_done, r_state == S_DIV1 || r_state == S_DIV2)
    `VRT_ASSERT_NEXT(a_start_setup, i_clk, i_rst_n, w_acc && s_axis_tuser == ACT_START, r_state == S_SETUP)

endmodule

FILE: rtl/core/vrt_div.sv
// Iterative restoring divider, one quotient bit per cycle, result saturated to 32 bits.
// Depends on vrt_pkg.
module vrt_div #(
    parameter int QW = 33
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [QW-1:0]            i_dividend,
    input  logic [vrt_pkg::DIR_W-1:0] i_divisor,
    output logic                     o_done,
    output logic [vrt_pkg::BND_W-1:0] o_quot
);
    import vrt_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic [QW-1:0]    r_dvd;
    logic [QW-1:0]    r_q;
    logic [DIR_W-1:0] r_rem;
    logic [DIR_W-1:0] r_dsr;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DIR_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_dvd[QW-1]};
    assign w_ge = w_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? DIR_W'(w_sh - {1'b0, r_dsr}) : w_sh[DIR_W-1:0];
                r_q   <= {r_q[QW-2:0], w_ge};
                r_dvd <= {r_dvd[QW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = (r_q[QW-1:BND_W] != '0) ? '1 : r_q[BND_W-1:0];

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for voxel_ray_traversal: a streaming driver and monitor
// answer the walker's voxel queries and check every word against a built-in predictor.
// Depends on vrt_pkg and the RTL of voxel_ray_traversal.
`timescale 1ns / 1ps

module testbench;
    import vrt_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYC = 300;

    typedef struct {
        logic        act;
        logic [31:0] org [3];
        logic [17:0] dir [3];
        logic [31:0] len;
        logic        solid;
    } ray_word_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [15:0]       vox [3];
    } walk_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic i_cfg_wr_data = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0] m_axis_tuser;

    voxel_ray_traversal DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // walker state mirror
    logic        ahead_md;
    logic [15:0] cur_vox [3];
    logic [15:0] prev_vox [3];
    logic [31:0] next_bnd [3];
    logic [31:0] bnd_inc [3];
    int          step_dir [3];
    longint      ray_org [3];
    logic [31:0] ray_len;
    bit          first_step;
    bit          walking;

    ray_word_t   word_q [$];
    walk_res_t   expected_q [$];
    ray_word_t   held;
    int          gap_cnt = 0;
    int          stall_cnt = 0;
    bit          quiet = 0;
    int          errors = 0;
    int          words_sent = 0;
    int          results_seen = 0;
    int          hits = 0;
    int          misses = 0;

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic bit beyond_length();
        logic [63:0] sum, sq, a, lsq;
        longint d;
        sum = 0;
        lsq = 64'(ray_len);
        for (int i = 0; i < 3; i++) begin
            d = ray_org[i] - longint'($signed(cur_vox[i])) * 65536;
            a = (d < 0) ? 64'(-d) : 64'(d);
            if (a > lsq) return 1;
            sq = a * a;
            if (sum + sq < sum) return 1;
            sum = sum + sq;
        end
        return sum > lsq * lsq;
    endfunction

    // x wins ties over y, y over z
    function automatic void step_voxel();
        int ax;
        if (step_dir[0] != 0 && (step_dir[1] == 0 || next_bnd[0] <= next_bnd[1]) &&
            (step_dir[2] == 0 || next_bnd[0] <= next_bnd[2]))
            ax = 0;
        else if (step_dir[1] != 0 && (step_dir[2] == 0 || next_bnd[1] <= next_bnd[2]))
            ax = 1;
        else
            ax = 2;
        cur_vox[ax] = cur_vox[ax] + 16'(step_dir[ax]);
        next_bnd[ax] = sat32(64'(next_bnd[ax]) + 64'(bnd_inc[ax]));
    endfunction

    function automatic walk_res_t check_and_step();
        walk_res_t r;
        if (beyond_length()) begin
            walking = 0;
            r.kind = KIND_MISS;
            r.vox = '{16'h0, 16'h0, 16'h0};
        end else begin
            step_voxel();
            r.kind = KIND_QUERY;
            r.vox = cur_vox;
        end
        return r;
    endfunction

    function automatic bit predict_walk(ray_word_t w, output walk_res_t r);
        longint o, d;
        logic [63:0] ad, fr, bdist;
        if (w.act == ACT_START) begin
            for (int i = 0; i < 3; i++) begin
                o = longint'($signed(w.org[i]));
                d = longint'($signed(w.dir[i]));
                ad = (d < 0) ? 64'(-d) : 64'(d);
                fr = 64'(o) & 64'hFFFF;
                ray_org[i] = o;
                cur_vox[i] = 16'(o >>> 16);
                prev_vox[i] = cur_vox[i];
                step_dir[i] = (d > 0) ? 1 : ((d < 0) ? -1 : 0);
                if (ad == 0) begin
                    bnd_inc[i] = 32'hFFFF_FFFF;
                    next_bnd[i] = 32'hFFFF_FFFF;
                end else begin
                    bdist = (d > 0) ? ((64'h1_0000 - fr) & 64'hFFFF) : fr;
                    bnd_inc[i] = sat32((64'd1 << 32) / ad);
                    next_bnd[i] = sat32((bdist << 16) / ad);
                end
            end
            ray_len = w.len;
            first_step = 1;
            if (step_dir[0] == 0 && step_dir[1] == 0 && step_dir[2] == 0) begin
                walking = 0;
                r.kind = KIND_MISS;
                r.vox = '{16'h0, 16'h0, 16'h0};
                return 1;
            end
            walking = 1;
            r = check_and_step();
            return 1;
        end
        if (!walking) return 0;
        if (w.solid) begin
            if (!ahead_md || !first_step) begin
                walking = 0;
                r.kind = KIND_HIT;
                r.vox = ahead_md ? prev_vox : cur_vox;
                return 1;
            end
        end
        prev_vox = cur_vox;
        first_step = 0;
        r = check_and_step();
        return 1;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // driver: hold a word until taken, random gaps between words
    always @(posedge i_clk) begin : drive_p
        walk_res_t r;
        bit nv;
        if (i_rst_n) begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                if (predict_walk(held, r)) expected_q.push_back(r);
                nv = 0;
            end
            if (!nv) begin
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (word_q.size() > 0) begin
                    held = word_q.pop_front();
                    s_axis_tdata <= {1'b0, held.solid, held.len, held.dir[2], held.dir[1],
                                     held.dir[0], held.org[2], held.org[1], held.org[0]};
                    s_axis_tuser <= held.act;
                    nv = 1;
                    if (!quiet && $urandom_range(0, 3) == 0) gap_cnt = $urandom_range(1, 3);
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // monitor: check each result word against the oldest prediction
    always @(posedge i_clk) begin : mon_p
        walk_res_t e;
        logic [15:0] got [3];
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32]};
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word kind %0d", m_axis_tuser));
                end else begin
                    e = expected_q.pop_front();
                    if (e.kind == KIND_HIT) hits++;
                    if (e.kind == KIND_MISS) misses++;
                    if (m_axis_tuser !== e.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", m_axis_tuser, e.kind));
                    for (int i = 0; i < 3; i++)
                        if (got[i] !== e.vox[i])
                            report_mismatch($sformatf("voxel axis %0d: %h, want %h",
                                                      i, got[i], e.vox[i]));
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_axis_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                stall_cnt = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any handshake
    int idle_cyc = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            i_cfg_wr_en)
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    task automatic settle();
        do @(negedge i_clk);
        while (word_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
    endtask

    // each word waits until taken and until its result, if any, is seen, so the sender always drains the block
    task automatic send(ray_word_t w);
        words_sent++;
        word_q.push_back(w);
        settle();
    endtask

    task automatic set_ahead(logic v);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        ahead_md = v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic ray_word_t mk_start(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                           logic [17:0] dx, logic [17:0] dy, logic [17:0] dz,
                                           logic [31:0] len);
        ray_word_t w;
        w.act = ACT_START;
        w.org = '{ox, oy, oz};
        w.dir = '{dx, dy, dz};
        w.len = len;
        w.solid = $urandom_range(0, 1);
        return w;
    endfunction

    // answers carry random filler in the unused fields
    function automatic ray_word_t mk_answer(logic solid);
        ray_word_t w;
        w.act = ACT_ANSWER;
        w.org = '{$urandom, $urandom, $urandom};
        w.dir = '{18'($urandom), 18'($urandom), 18'($urandom)};
        w.len = $urandom;
        w.solid = solid;
        return w;
    endfunction

    function automatic ray_word_t rand_start();
        ray_word_t w;
        w = mk_start(0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 3; i++) begin
            if ($urandom_range(0, 3) == 0) w.org[i] = $urandom;
            else w.org[i] = $urandom_range(0, 40 << 16) - (20 << 16);
            w.dir[i] = ($urandom_range(0, 7) == 0) ? 18'h0 : 18'($urandom);
        end
        w.len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 10 << 16);
        return w;
    endfunction

    // start a ray and answer queries; a walk cut off at the cap is dropped by the next start
    task automatic walk_ray(ray_word_t w, int cap, int solid_pct);
        int n;
        n = 0;
        send(w);
        while (walking && n < cap) begin
            send(mk_answer($urandom_range(1, 100) <= solid_pct));
            n++;
        end
    endtask

    task automatic random_phase(int limit_words);
        while (words_sent < limit_words) begin
            walk_ray(rand_start(), 12, 15);
            if ($urandom_range(0, 7) == 0) send(mk_answer($urandom_range(0, 1)));
        end
    endtask

    initial begin
        ahead_md = 1'b0;
        walking = 0;
        first_step = 1;
        ray_len = '0;
        for (int i = 0; i < 3; i++) begin
            cur_vox[i] = '0; prev_vox[i] = '0; next_bnd[i] = '0; bnd_inc[i] = '0;
            step_dir[i] = 0; ray_org[i] = 0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_ahead(1'b0);

        // directed rays
        send(mk_start(32'h0001_8000, 0, 0, 0, 0, 0, 32'h0010_0000));         // zero direction
        send(mk_answer(1'b1));                                                // answer while idle
        walk_ray(mk_start(32'h0000_8000, 0, 0, 18'h10000, 0, 0, 32'h0003_0000), 3, 0);
        walk_ray(mk_start(0, 32'hFFFE_4000, 0, 0, 18'h30000, 0, 32'h0004_0000), 1, 100);
        walk_ray(mk_start(0, 0, 32'h0000_0001, 0, 0, 18'h1FFFF, 32'h0002_0000), 2, 0);
        walk_ray(mk_start(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          18'h20000, 18'h20000, 18'h20000, 32'hFFFF_FFFF), 4, 0);
        walk_ray(mk_start(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          18'h1FFFF, 18'h20000, 18'h00001, 32'h0000_0000), 2, 0);
        walk_ray(mk_start(0, 0, 0, 18'h10000, 18'h10000, 18'h10000, 32'h0004_0000), 6, 0);
        walk_ray(mk_start(32'hFFFF_0000, 32'h0000_FFFF, 32'h0002_0000,
                          18'h3FFFF, 18'h00001, 18'h2C000, 32'hFFFF_FFFF), 3, 0);
        send(mk_answer(1'b1));                                                // hit after cap

        set_ahead(1'b1);
        walk_ray(mk_start(0, 0, 0, 18'h10000, 0, 0, 32'h0008_0000), 1, 100);  // solid first step
        send(mk_answer(1'b1));
        random_phase(600);
        set_ahead(1'b0);
        random_phase(1100);
        set_ahead(1'b1);
        random_phase(1500);
        quiet = 1;
        random_phase(1900);

        settle();
        repeat (SETTLE_CYC) @(posedge i_clk);
        foreach (expected_q[i]) report_mismatch("result never arrived");
        $display("Covered %0d input words, %0d result words (%0d hits, %0d misses),",
                 words_sent, results_seen, hits, misses);
        $display("both ahead settings, stalls on both sides, and a quiet final stretch.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
